// ===== hw/rtl/afps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package afps_pkg;

  // Field widths of the channels.
  localparam int unsigned POWER_W    = 24;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned SNR_W      = 16;
  localparam int unsigned PEAK_W     = 8;
  localparam int unsigned PSUM_W     = 27;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned BINS_W     = 9;
  localparam int unsigned DEPTH_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd2;

  localparam logic               MODE_RESET  = 1'b1;
  localparam logic [BINS_W-1:0]  BINS_RESET  = 9'd64;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREQ,
    ST_DIV,
    ST_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic clear;
    logic store;
    logic start_scan;
    logic start_freq;
    logic start_div;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic last_bin;
    logic scan_done;
    logic freq_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/afps_bin_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface afps_bin_if;
  import afps_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [POWER_W-1:0]       bin_power;
  logic signed [FREQ_W-1:0] bin_freq;
  logic signed [SNR_W-1:0]  bin_snr;

  modport source (output valid, bin_power, bin_freq, bin_snr, input ready);
  modport sink (input valid, bin_power, bin_freq, bin_snr, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/afps_sym_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface afps_sym_if;
  import afps_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     symbol_bit;
  logic [PEAK_W-1:0]        peak_bin;
  logic [PSUM_W-1:0]        peak_power_sum;
  logic signed [FREQ_W-1:0] freq_threshold;
  logic signed [SNR_W-1:0]  peak_snr;

  modport source (
    output valid, symbol_bit, peak_bin, peak_power_sum, freq_threshold, peak_snr,
    input ready
  );
  modport sink (
    input valid, symbol_bit, peak_bin, peak_power_sum, freq_threshold, peak_snr,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/afps_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface afps_cfg_if;
  import afps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/afps_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module afps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/afps_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module afps_div #(
  parameter int unsigned NW = 19,
  parameter int unsigned DW = 4
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               busy_o,
  output logic      [NW-1:0] quot_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dvs_q;
  logic [DW:0]   rem_sh;
  logic          q_bit;
  logic [DW:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_q, quo_q[NW-1]};
    q_bit   = (rem_sh >= {1'b0, dvs_q});
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NW-2:0], q_bit};
      rem_q <= q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/afps_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module afps_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire afps_pkg::dp_status_t status_i,
  output afps_pkg::dp_cmd_t         cmd_o
);
  import afps_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.store = in_valid_i;
        if (in_valid_i && status_i.last_bin) begin
          cmd_o.start_scan = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          cmd_o.start_freq = 1'b1;
          state_d          = ST_FREQ;
        end
      end
      ST_FREQ: begin
        if (status_i.freq_done) begin
          cmd_o.start_div = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/afps_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module afps_dp #(
  parameter int unsigned MAX_BINS = 256,
  parameter int unsigned MAX_AVG  = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire afps_pkg::dp_cmd_t                   cmd_i,
  output afps_pkg::dp_status_t                     status_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [afps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [afps_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic [afps_pkg::POWER_W-1:0]        bin_power_i,
  input  wire logic signed [afps_pkg::FREQ_W-1:0]  bin_freq_i,
  input  wire logic signed [afps_pkg::SNR_W-1:0]   bin_snr_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     symbol_bit_o,
  output logic [afps_pkg::PEAK_W-1:0]              peak_bin_o,
  output logic [afps_pkg::PSUM_W-1:0]              peak_power_sum_o,
  output logic signed [afps_pkg::FREQ_W-1:0]       freq_threshold_o,
  output logic signed [afps_pkg::SNR_W-1:0]        peak_snr_o
);
  import afps_pkg::*;

  localparam int unsigned DEPTH = MAX_AVG * MAX_BINS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned BW    = $clog2(MAX_BINS);
  localparam int unsigned RW    = (MAX_AVG > 1) ? $clog2(MAX_AVG) : 1;
  localparam int unsigned NBW   = $clog2(MAX_BINS + 1);
  localparam int unsigned DW    = $clog2(MAX_AVG + 1);
  localparam int unsigned SW    = POWER_W + $clog2(MAX_AVG + 1);
  localparam int unsigned FW    = FREQ_W + $clog2(MAX_AVG + 1);
  localparam int unsigned WW    = POWER_W + FREQ_W;

  // Configuration registers.
  logic               mode_q;
  logic [BINS_W-1:0]  bins_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [NBW-1:0]     nb;
  logic [DW-1:0]      nd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RESET;
      bins_q  <= BINS_RESET;
      depth_q <= DEPTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:  mode_q  <= cfg_data_i[0];
        CFG_BINS:  bins_q  <= cfg_data_i[BINS_W-1:0];
        CFG_DEPTH: depth_q <= cfg_data_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bins_q < BINS_W'(2)) begin
      nb = NBW'(2);
    end else if (32'(bins_q) > MAX_BINS) begin
      nb = NBW'(MAX_BINS);
    end else begin
      nb = NBW'(bins_q);
    end
    if (depth_q == '0) begin
      nd = DW'(1);
    end else if (32'(depth_q) > MAX_AVG) begin
      nd = DW'(MAX_AVG);
    end else begin
      nd = DW'(depth_q);
    end
  end

  // Symbol position and ring row.
  logic [BW-1:0] bin_cnt_q;
  logic [RW-1:0] row_q;
  logic [BW-1:0] last_peak_q;
  logic          last_bin;

  assign last_bin = (32'(bin_cnt_q) + 32'd1) >= 32'(nb);

  // Clearing pass counter.
  logic [AW-1:0] clr_q;
  logic          clr_last;

  assign clr_last = (clr_q == AW'(DEPTH - 1));

  // Scan and frequency read sequencing.
  logic          sc_run_q, fr_run_q;
  logic [BW-1:0] sc_bin_q;
  logic [RW-1:0] sc_row_q, fr_row_q;
  logic          sc_row_end, sc_bin_end, fr_row_end;
  logic          rd_vld_q, rd_fvld_q;
  logic          rd_first_q, rd_last_q;
  logic [BW-1:0] rd_bin_q;
  logic [RW-1:0] rd_row_q;

  assign sc_row_end = (32'(sc_row_q) + 32'd1) >= 32'(nd);
  assign sc_bin_end = (32'(sc_bin_q) + 32'd1) >= 32'(nb);
  // The peak reads cover the averaged rows and also the current row when the
  // row pointer lies past the averaging depth.
  assign fr_row_end = ((32'(fr_row_q) + 32'd1) >= 32'(nd)) && (fr_row_q >= row_q);

  // Ring store: power in the upper bits, frequency in the lower bits.
  logic          st_we, st_re;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [WW-1:0] st_wdata, st_rdata;
  logic          snr_we;
  logic [BW-1:0] snr_waddr;
  logic [SNR_W-1:0] snr_wdata, snr_rdata;

  always_comb begin
    st_we     = cmd_i.clear | cmd_i.store;
    st_waddr  = cmd_i.clear ? clr_q : AW'(32'(row_q) * MAX_BINS + 32'(bin_cnt_q));
    st_wdata  = cmd_i.clear ? '0 : {bin_power_i, bin_freq_i};
    st_re     = sc_run_q | fr_run_q;
    st_raddr  = sc_run_q ? AW'(32'(sc_row_q) * MAX_BINS + 32'(sc_bin_q))
                         : AW'(32'(fr_row_q) * MAX_BINS + 32'(last_peak_q));
    snr_we    = (cmd_i.clear && (32'(clr_q) < MAX_BINS)) || cmd_i.store;
    snr_waddr = cmd_i.clear ? clr_q[BW-1:0] : bin_cnt_q;
    snr_wdata = cmd_i.clear ? '0 : bin_snr_i;
  end

  afps_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // The SNR row is read at the peak, which holds still once the scan ends.
  afps_ram #(
    .WIDTH (SNR_W),
    .DEPTH (MAX_BINS)
  ) u_snr_ram (
    .clk_i   (clk_i),
    .we_i    (snr_we),
    .waddr_i (snr_waddr),
    .wdata_i (snr_wdata),
    .re_i    (1'b1),
    .raddr_i (last_peak_q),
    .rdata_o (snr_rdata)
  );

  // Accumulation.
  logic [SW-1:0]        acc_q, best_q, acc_sum;
  logic [BW-1:0]        peak_q;
  logic signed [FW-1:0] fsum_q, rd_freq_ext;
  logic signed [FREQ_W-1:0] cur_q;
  logic signed [FW-1:0] cur_ext, nd_ext, prod_q;
  logic signed [FW-1:0] prod_full;

  always_comb begin
    acc_sum     = (rd_first_q ? '0 : acc_q) + SW'(st_rdata[WW-1:FREQ_W]);
    rd_freq_ext = {{(FW - FREQ_W){st_rdata[FREQ_W-1]}}, st_rdata[FREQ_W-1:0]};
    cur_ext     = {{(FW - FREQ_W){cur_q[FREQ_W-1]}}, cur_q};
    nd_ext      = FW'(nd);
    prod_full   = cur_ext * nd_ext;
  end

  // Threshold division.
  logic          div_busy;
  logic [FW-1:0] div_quot, fsum_abs;
  logic [FW-1:0] thr_full;
  logic          bit_d;

  assign fsum_abs = fsum_q[FW-1] ? FW'(-fsum_q) : FW'(fsum_q);

  afps_div #(
    .NW (FW),
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start_div),
    .dividend_i (fsum_abs),
    .divisor_i  (nd),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  always_comb begin
    thr_full = fsum_q[FW-1] ? (~div_quot + FW'(1)) : div_quot;
    bit_d    = mode_q ? (prod_q >= fsum_q) : !cur_q[FREQ_W-1];
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_cnt_q   <= '0;
      row_q       <= '0;
      last_peak_q <= '0;
      clr_q       <= '0;
      sc_run_q    <= 1'b0;
      fr_run_q    <= 1'b0;
      rd_vld_q    <= 1'b0;
      rd_fvld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.store) begin
        bin_cnt_q <= last_bin ? '0 : bin_cnt_q + BW'(1);
      end

      rd_vld_q  <= sc_run_q;
      rd_fvld_q <= fr_run_q;

      if (cmd_i.start_scan) begin
        sc_run_q <= 1'b1;
      end else if (sc_run_q && sc_row_end && sc_bin_end) begin
        sc_run_q <= 1'b0;
      end

      if (cmd_i.start_freq) begin
        fr_run_q    <= 1'b1;
        last_peak_q <= peak_q;
      end else if (fr_run_q && fr_row_end) begin
        fr_run_q <= 1'b0;
      end

      if (cmd_i.load_result) begin
        row_q       <= ((32'(row_q) + 32'd1) >= 32'(nd)) ? '0 : row_q + RW'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic                     out_bit_q;
  logic [PEAK_W-1:0]        out_peak_q;
  logic [PSUM_W-1:0]        out_sum_q;
  logic signed [FREQ_W-1:0] out_thr_q;
  logic signed [SNR_W-1:0]  out_snr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_scan) begin
      sc_bin_q <= '0;
      sc_row_q <= '0;
      best_q   <= '0;
      peak_q   <= last_peak_q;
    end else if (sc_run_q) begin
      if (sc_row_end) begin
        sc_row_q <= '0;
        sc_bin_q <= sc_bin_q + BW'(1);
      end else begin
        sc_row_q <= sc_row_q + RW'(1);
      end
    end

    if (cmd_i.start_freq) begin
      fr_row_q <= '0;
      fsum_q   <= '0;
    end else if (fr_run_q) begin
      fr_row_q <= fr_row_q + RW'(1);
    end

    rd_first_q <= sc_run_q ? (sc_row_q == '0) : 1'b0;
    rd_last_q  <= sc_row_end;
    rd_bin_q   <= sc_bin_q;
    rd_row_q   <= fr_row_q;

    if (rd_vld_q) begin
      acc_q <= acc_sum;
      // Strictly greater, so the lowest bin keeps a tie.
      if (rd_last_q && (acc_sum > best_q)) begin
        best_q <= acc_sum;
        peak_q <= rd_bin_q;
      end
    end

    if (rd_fvld_q) begin
      if (32'(rd_row_q) < 32'(nd)) begin
        fsum_q <= fsum_q + rd_freq_ext;
      end
      if (rd_row_q == row_q) begin
        cur_q <= st_rdata[FREQ_W-1:0];
      end
    end

    if (cmd_i.start_div) begin
      prod_q <= prod_full;
    end

    if (cmd_i.load_result) begin
      out_bit_q  <= bit_d;
      out_peak_q <= PEAK_W'(last_peak_q);
      out_sum_q  <= PSUM_W'(best_q);
      out_thr_q  <= mode_q ? thr_full[FREQ_W-1:0] : '0;
      out_snr_q  <= snr_rdata;
    end
  end

  always_comb begin
    status_o.clear_done = clr_last;
    status_o.last_bin   = last_bin;
    status_o.scan_done  = !sc_run_q && !rd_vld_q;
    status_o.freq_done  = !fr_run_q && !rd_fvld_q;
    status_o.div_done   = !div_busy;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign symbol_bit_o     = out_bit_q;
  assign peak_bin_o       = out_peak_q;
  assign peak_power_sum_o = out_sum_q;
  assign freq_threshold_o = out_thr_q;
  assign peak_snr_o       = out_snr_q;

endmodule

`default_nettype wire

// ===== hw/rtl/averaged_fft_peak_fsk_slicer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Transaction
// bin_i    in         one FFT bin: bin_power, bin_freq, bin_snr
// sym_o    out        one symbol: symbol_bit, peak_bin, peak_power_sum,
//                     freq_threshold, peak_snr
// cfg_i    in         register write: index, data (0 mode, 1 bins_used, 2 avg_depth)
//
// Bins other than the last of a symbol are accepted one per cycle while idle. The last bin
// starts a scan of bins_used * avg_depth ring words, one per cycle, then avg_depth reads at
// the peak (row pointer + 1 reads if that is more) and a division of the 20-bit frequency
// sum by avg_depth: the result turns valid in the same cycle as bins are accepted again.
// After reset a clearing pass over all MAX_AVG * MAX_BINS ring words holds off bins, not
// register writes. A held result stalls bins only once the next symbol has finished.
module averaged_fft_peak_fsk_slicer #(
  parameter int unsigned MAX_BINS = 256,
  parameter int unsigned MAX_AVG  = 8
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  afps_bin_if.sink    bin_i,
  afps_sym_if.source  sym_o,
  afps_cfg_if.sink    cfg_i
);
  import afps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_i.ready = 1'b1;

  afps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (bin_i.valid),
    .in_ready_o (bin_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  afps_dp #(
    .MAX_BINS (MAX_BINS),
    .MAX_AVG  (MAX_AVG)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .bin_power_i      (bin_i.bin_power),
    .bin_freq_i       (bin_i.bin_freq),
    .bin_snr_i        (bin_i.bin_snr),
    .out_valid_o      (sym_o.valid),
    .out_ready_i      (sym_o.ready),
    .symbol_bit_o     (sym_o.symbol_bit),
    .peak_bin_o       (sym_o.peak_bin),
    .peak_power_sum_o (sym_o.peak_power_sum),
    .freq_threshold_o (sym_o.freq_threshold),
    .peak_snr_o       (sym_o.peak_snr)
  );

endmodule

`default_nettype wire
